/* src/page_allocator_aging_swap_assert.svh */
// Assertion macros for the page allocator with aging replacement.
`ifndef PAGE_ALLOCATOR_AGING_SWAP_ASSERT_SVH
`define PAGE_ALLOCATOR_AGING_SWAP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PGA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PGA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pgalloc_pkg.sv */
// Shared constants, link and command types for the page allocator.
package pgalloc_pkg;

    localparam int MAX_PAGES  = 16;
    localparam int PAGE_BYTES = 4194304;
    localparam int AGE_BITS   = 8;

    localparam int IDX_W      = $clog2(MAX_PAGES);
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int FILL_W     = $clog2(PAGE_BYTES + 1);
    localparam int SIZE_W     = 22;
    localparam int SUM_W      = ((FILL_W > SIZE_W) ? FILL_W : SIZE_W) + 1;
    localparam int FRAME_W    = 4;
    localparam int RF_W       = 5;
    localparam int PNUM_W     = 5;
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 24;

    localparam logic [RF_W-1:0]     RF_RESET = RF_W'(3);
    localparam logic [AGE_BITS-1:0] AGE_TOP  = {1'b1, {(AGE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VICTIM
    } st_t;

    // Token handed from cell to cell.
    typedef struct packed {
        logic                scan;
        logic                vic;
        logic [SIZE_W-1:0]   size;
        logic                found;
        logic [IDX_W-1:0]    hit_idx;
        logic [FILL_W-1:0]   hit_fill;
        logic                hit_res;
        logic [FRAME_W-1:0]  hit_frame;
        logic                have_vic;
        logic [AGE_BITS-1:0] best_age;
        logic [IDX_W-1:0]    vic_idx;
        logic [FRAME_W-1:0]  vic_frame;
    } link_t;

    // Broadcast from the controller to all cells.
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [IDX_W-1:0]   chosen;
        logic               init_page;
        logic               init_res;
        logic               commit;
        logic [FILL_W-1:0]  fill_val;
        logic               load;
        logic [FRAME_W-1:0] frame_val;
        logic               evict;
        logic [IDX_W-1:0]   vic_idx;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [PNUM_W-1:0]  page_number;
        logic [FRAME_W-1:0] frame_index;
        logic               swap_done;
        logic [PNUM_W-1:0]  evicted_page;
        logic               load_from_disk;
        logic               full_res;
    } res_t;

endpackage

/* src/pgalloc_cell.sv */
// One page cell: fill, age, residency and frame, with the scan and victim token stage.
module pgalloc_cell
    import pgalloc_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  link_t link_in,
    output link_t link_out
);

    localparam logic [IDX_W-1:0]   MY_IDX   = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0]   MY_CNT   = CNT_W'(CELL_IDX);
    localparam logic [FRAME_W-1:0] MY_FRAME = FRAME_W'(CELL_IDX);

    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [AGE_BITS-1:0] age_reg, age_next;
    logic                res_reg, res_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    link_t               link_reg, link_next;

    logic               active;
    logic               is_chosen;
    logic [SUM_W-1:0]   sum;

    always_comb
    begin
        link_next  = link_in;
        fill_next  = fill_reg;
        age_next   = age_reg;
        res_next   = res_reg;
        frame_next = frame_reg;
        active     = MY_CNT < cmd.count;
        is_chosen  = cmd.chosen == MY_IDX;
        sum        = SUM_W'(fill_reg) + SUM_W'(link_in.size);

        if (link_in.scan && active && !link_in.found)
        begin
            age_next = age_reg >> 1;
            if (sum < SUM_W'(PAGE_BYTES))
            begin
                age_next           = age_next | AGE_TOP;
                link_next.found    = 1'b1;
                link_next.hit_idx  = MY_IDX;
                link_next.hit_fill = fill_reg;
                link_next.hit_res  = res_reg;
                link_next.hit_frame = frame_reg;
            end
        end

        // ages compared before the shift; later page wins ties
        if (link_in.vic && active && res_reg)
        begin
            if (!is_chosen && (!link_in.have_vic || age_reg <= link_in.best_age))
            begin
                link_next.have_vic  = 1'b1;
                link_next.best_age  = age_reg;
                link_next.vic_idx   = MY_IDX;
                link_next.vic_frame = frame_reg;
            end
            age_next = age_reg >> 1;
        end

        if (cmd.init_page && is_chosen)
        begin
            age_next   = AGE_TOP;
            res_next   = cmd.init_res;
            frame_next = MY_FRAME;
        end

        if (cmd.commit && is_chosen)
        begin
            fill_next = cmd.fill_val;
            if (cmd.load)
            begin
                res_next   = 1'b1;
                frame_next = cmd.frame_val;
            end
        end

        if (cmd.commit && cmd.evict && (cmd.vic_idx == MY_IDX))
        begin
            res_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            age_reg   <= '0;
            res_reg   <= (CELL_IDX == 0);
            frame_reg <= MY_FRAME;
            link_reg  <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            age_reg   <= age_next;
            res_reg   <= res_next;
            frame_reg <= frame_next;
            link_reg  <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

/* src/pgalloc_ctrl.sv */
// Request sequencer: injects tokens, decides the page, commits and registers the result.
module pgalloc_ctrl
    import pgalloc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SIZE_W-1:0] alloc_size,
    input  logic              cfg_wr_en,
    input  logic [RF_W-1:0]   cfg_wr_data,
    input  link_t             tail,
    output link_t             head,
    output cmd_t              cmd,
    output logic              busy,
    output logic              done,
    output res_t              result
);

    st_t                state_reg, state_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [RF_W-1:0]    rf_reg, rf_next;
    logic [IDX_W-1:0]   chosen_reg, chosen_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               wasres_reg, wasres_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               done_reg, done_next;
    res_t               result_reg, result_next;

    logic               finish;
    logic               full;
    logic               init_res;
    logic               have;
    logic [IDX_W-1:0]   vic_idx;
    logic [FRAME_W-1:0] vic_frame;
    logic [SUM_W-1:0]   sum;
    logic [FILL_W-1:0]  fill_sat;
    logic [CNT_W-1:0]   page;

    always_comb
    begin
        state_next  = state_reg;
        size_next   = size_reg;
        count_next  = count_reg;
        rf_next     = cfg_wr_en ? cfg_wr_data : rf_reg;
        chosen_next = chosen_reg;
        fill_next   = fill_reg;
        wasres_next = wasres_reg;
        frame_next  = frame_reg;
        head        = '0;
        cmd         = '0;
        finish      = 1'b0;
        full        = 1'b0;
        have        = 1'b0;
        vic_idx     = '0;
        vic_frame   = '0;
        init_res    = ((CNT_W+1)'(count_reg) + (CNT_W+1)'(1)) <= (CNT_W+1)'(rf_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    head.scan  = 1'b1;
                    head.size  = alloc_size;
                    size_next  = alloc_size;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail.scan)
                begin
                    if (tail.found)
                    begin
                        chosen_next = tail.hit_idx;
                        fill_next   = tail.hit_fill;
                        wasres_next = tail.hit_res;
                        frame_next  = tail.hit_frame;
                    end
                    else if (count_reg >= CNT_W'(MAX_PAGES))
                    begin
                        full = 1'b1;
                    end
                    else
                    begin
                        chosen_next   = count_reg[IDX_W-1:0];
                        fill_next     = '0;
                        wasres_next   = init_res;
                        frame_next    = FRAME_W'(count_reg[IDX_W-1:0]);
                        cmd.init_page = 1'b1;
                        cmd.init_res  = init_res;
                        count_next    = count_reg + CNT_W'(1);
                    end
                    if (full || wasres_next)
                    begin
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        head.vic   = 1'b1;
                        head.size  = size_reg;
                        state_next = ST_VICTIM;
                    end
                end
            end
            ST_VICTIM:
            begin
                if (tail.vic)
                begin
                    have       = tail.have_vic;
                    vic_idx    = tail.vic_idx;
                    vic_frame  = tail.vic_frame;
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        sum      = SUM_W'(fill_next) + SUM_W'(size_reg);
        fill_sat = (sum > SUM_W'(PAGE_BYTES)) ? FILL_W'(PAGE_BYTES) : sum[FILL_W-1:0];

        cmd.count     = count_reg;
        cmd.chosen    = chosen_next;
        cmd.commit    = finish && !full;
        cmd.fill_val  = fill_sat;
        cmd.load      = !wasres_next;
        cmd.frame_val = have ? vic_frame : FRAME_W'(chosen_next);
        cmd.evict     = have;
        cmd.vic_idx   = vic_idx;

        page = CNT_W'(chosen_next) + CNT_W'(1);
        result_next = '0;
        if (full)
        begin
            result_next.full_res = 1'b1;
        end
        else
        begin
            result_next.address = {(ADDR_W-PAGE_SHIFT)'(page), {PAGE_SHIFT{1'b0}}}
                                  | ADDR_W'(fill_next);
            result_next.page_number    = PNUM_W'(page);
            result_next.frame_index    = wasres_next ? frame_next : cmd.frame_val;
            result_next.swap_done      = !wasres_next && have;
            result_next.evicted_page   = (!wasres_next && have)
                                         ? PNUM_W'(CNT_W'(vic_idx) + CNT_W'(1)) : '0;
            result_next.load_from_disk = !wasres_next && (fill_next != '0);
        end
        done_next = finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= CNT_W'(1);
            rf_reg    <= RF_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rf_reg    <= rf_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        chosen_reg <= chosen_next;
        fill_reg   <= fill_next;
        wasres_reg <= wasres_next;
        frame_reg  <= frame_next;
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* src/page_allocator_aging_swap.sv */
// Page allocator with aging replacement: controller plus a chain of page cells.
// The strobe follows the scan token through the chain when the page is resident or the request is refused;
// a victim scan follows the first scan otherwise; each scan is one cell per cycle down the chain.
// A new request is taken only once the previous one has finished; start is taken in the strobe cycle.
// Reset: page one resident in frame 0, page count one, resident_frames 3.
`include "page_allocator_aging_swap_assert.svh"

module page_allocator_aging_swap
    import pgalloc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SIZE_W-1:0]   alloc_size,
    input  logic                cfg_wr_en,
    input  logic [RF_W-1:0]     cfg_wr_data,
    output logic                done,
    output logic [ADDR_W-1:0]   address,
    output logic [PNUM_W-1:0]   page_number,
    output logic [FRAME_W-1:0]  frame_index,
    output logic                swap_done,
    output logic [PNUM_W-1:0]   evicted_page,
    output logic                load_from_disk,
    output logic                full_res
);

    link_t link [0:MAX_PAGES];
    cmd_t  cmd;
    res_t  result;

    pgalloc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .alloc_size  (alloc_size),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tail        (link[MAX_PAGES]),
        .head        (link[0]),
        .cmd         (cmd),
        .busy        (busy),
        .done        (done),
        .result      (result)
    );

    for (genvar i = 0; i < MAX_PAGES; i++)
    begin : g_cell
        pgalloc_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .link_in  (link[i]),
            .link_out (link[i+1])
        );
    end

    assign address        = result.address;
    assign page_number    = result.page_number;
    assign frame_index    = result.frame_index;
    assign swap_done      = result.swap_done;
    assign evicted_page   = result.evicted_page;
    assign load_from_disk = result.load_from_disk;
    assign full_res       = result.full_res;

    `PGA_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "start transfer not followed by busy")
    `PGA_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe held two cycles")
    `PGA_ASSERT_NOW(a_full_clean, done && full_res, page_number == '0 && address == '0 && !swap_done, "refused request carries a page")
    `PGA_ASSERT_NOW(a_evict_other, done && swap_done, evicted_page != page_number && evicted_page != '0, "bad evicted page")

endmodule
